[rtl/ocrt_pkg.sv]
// shared constants, types and helpers for the ordered completion ring tracker
package ocrt_pkg;

  localparam int RING_SLOTS = 128;
  localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W      = $clog2(RING_SLOTS + 1);

  localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd9216;

  typedef enum logic {
    OP_CLAIM    = 1'b0,
    OP_COMPLETE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    DROP_NONE       = 3'd0,
    DROP_NOT_UPLINK = 3'd1,
    DROP_NONLINEAR  = 3'd2,
    DROP_BAD_LEN    = 3'd3,
    DROP_RING_FULL  = 3'd4
  } drop_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_complete;
    logic scan_go;
    logic out_free;
  } dp_status_t;

  // slot that follows slot; zero after the last slot or where idx wraps
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [31:0] idx,
                                                 input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] r;
    if (idx == 32'hFFFF_FFFF) begin
      r = '0;
    end else if (slot == SLOT_W'(RING_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = slot + 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/ocrt_req_if.sv]
// request channel interface
interface ocrt_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        from_uplink;
  logic        is_linear;
  logic [15:0] frame_len;
  logic [31:0] consumer_index;
  logic [6:0]  done_slot;

  modport source (
    output valid, opcode, from_uplink, is_linear, frame_len, consumer_index, done_slot,
    input  ready
  );
  modport sink (
    input  valid, opcode, from_uplink, is_linear, frame_len, consumer_index, done_slot,
    output ready
  );
endinterface

[rtl/ocrt_rsp_if.sv]
// result channel interface
interface ocrt_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [6:0]  slot;
  logic [2:0]  drop_reason;
  logic [31:0] published_producer;

  modport source (
    output valid, accepted, slot, drop_reason, published_producer,
    input  ready
  );
  modport sink (
    input  valid, accepted, slot, drop_reason, published_producer,
    output ready
  );
endinterface

[rtl/ocrt_ctrl.sv]
// sequencing state machine for claim, completion and producer scan
module ocrt_ctrl
  import ocrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.is_complete ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (status.scan_go) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ocrt_dp.sv]
// ring indices, done flags, drop checks and result register
module ocrt_dp
  import ocrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        req_opcode,
  input  logic        req_from_uplink,
  input  logic        req_is_linear,
  input  logic [15:0] req_frame_len,
  input  logic [31:0] req_consumer_index,
  input  logic [6:0]  req_done_slot,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  ocrt_rsp_if.source  rsp
);

  logic [15:0]           max_frame_len;
  logic [31:0]           claim_index;
  logic [SLOT_W-1:0]     claim_slot;
  logic [31:0]           producer_index;
  logic [SLOT_W-1:0]     prod_slot;
  logic [RING_SLOTS-1:0] flags;
  logic [CNT_W-1:0]      scan_cnt;
  logic                  out_valid;

  logic        r_opcode;
  logic        r_from_uplink;
  logic        r_is_linear;
  logic [15:0] r_frame_len;
  logic [31:0] r_consumer;
  logic [6:0]  r_done_slot;

  logic        res_accepted;
  logic [6:0]  res_slot;
  drop_t       res_reason;

  logic        out_accepted;
  logic [6:0]  out_slot;
  logic [2:0]  out_reason;
  logic [31:0] out_producer;

  drop_t             exec_reason;
  logic              grant;
  logic              done_in_range;
  logic [SLOT_W-1:0] done_idx;
  logic [31:0]       occupancy;

  assign occupancy     = claim_index - r_consumer;
  assign done_in_range = 32'(r_done_slot) < 32'(RING_SLOTS);
  assign done_idx      = SLOT_W'(r_done_slot);

  always_comb begin
    priority if (!r_from_uplink) begin
      exec_reason = DROP_NOT_UPLINK;
    end else if (!r_is_linear) begin
      exec_reason = DROP_NONLINEAR;
    end else if (r_frame_len == 16'd0 || r_frame_len > max_frame_len) begin
      exec_reason = DROP_BAD_LEN;
    end else if (occupancy >= 32'(RING_SLOTS)) begin
      exec_reason = DROP_RING_FULL;
    end else begin
      exec_reason = DROP_NONE;
    end
  end

  assign grant = (exec_reason == DROP_NONE);

  assign status.is_complete = (r_opcode == OP_COMPLETE);
  assign status.scan_go     = (producer_index != claim_index) && flags[prod_slot] &&
                              (scan_cnt < CNT_W'(RING_SLOTS));
  assign status.out_free    = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len  <= MAX_FRAME_LEN_RESET;
      claim_index    <= '0;
      claim_slot     <= '0;
      producer_index <= '0;
      prod_slot      <= '0;
      flags          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_frame_len <= cfg_wdata;
      end
      if (cmd.exec && r_opcode == OP_CLAIM && grant) begin
        claim_index <= claim_index + 32'd1;
        claim_slot  <= slot_inc(claim_index, claim_slot);
      end
      if (cmd.exec && r_opcode == OP_COMPLETE && done_in_range) begin
        flags[done_idx] <= 1'b1;
      end
      if (cmd.scan_step) begin
        flags[prod_slot] <= 1'b0;
        producer_index   <= producer_index + 32'd1;
        prod_slot        <= slot_inc(producer_index, prod_slot);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_opcode      <= req_opcode;
      r_from_uplink <= req_from_uplink;
      r_is_linear   <= req_is_linear;
      r_frame_len   <= req_frame_len;
      r_consumer    <= req_consumer_index;
      r_done_slot   <= req_done_slot;
    end
    if (cmd.exec) begin
      scan_cnt <= '0;
      if (r_opcode == OP_COMPLETE) begin
        res_accepted <= 1'b1;
        res_slot     <= r_done_slot;
        res_reason   <= DROP_NONE;
      end else begin
        res_accepted <= grant;
        res_slot     <= grant ? 7'(claim_slot) : 7'd0;
        res_reason   <= exec_reason;
      end
    end
    if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (cmd.out_load) begin
      out_accepted <= res_accepted;
      out_slot     <= res_slot;
      out_reason   <= res_reason;
      out_producer <= producer_index;
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.accepted           = out_accepted;
  assign rsp.slot               = out_slot;
  assign rsp.drop_reason        = out_reason;
  assign rsp.published_producer = out_producer;

endmodule

[rtl/ordered_completion_ring_tracker.sv]
// top level of the ordered completion receive ring tracker
//
//   channel  dir  signals                                     request moves
//   req      in   valid ready opcode ... done_slot            claim or completion
//   rsp      out  valid ready accepted slot drop_reason ...   one result per request
//   cfg      in   cfg_we cfg_wdata                            max_frame_len write
//
// a claim goes from acceptance to result through the check and the result load
// a completion adds a scan between them that publishes one done slot per cycle
// reset: synchronous, clears indices and all done flags at once, no sweep
// the next request is accepted while the previous result waits in the output register
// a stalled result holds the block in its final step until taken
module ordered_completion_ring_tracker
  import ocrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  ocrt_req_if.sink    req,
  ocrt_rsp_if.source  rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign req.ready = in_ready;

  ocrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ocrt_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .req_opcode         (req.opcode),
    .req_from_uplink    (req.from_uplink),
    .req_is_linear      (req.is_linear),
    .req_frame_len      (req.frame_len),
    .req_consumer_index (req.consumer_index),
    .req_done_slot      (req.done_slot),
    .cmd                (cmd),
    .status             (status),
    .rsp                (rsp)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in progress");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp.valid)
    else $error("result load did not raise rsp valid");

  a_drop_has_reason: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.accepted |-> rsp.drop_reason != DROP_NONE)
    else $error("refused request without drop reason");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.drop_reason != DROP_NONE |-> !rsp.accepted && rsp.slot == 7'd0)
    else $error("dropped request reports a slot");

endmodule

[tb/tb_top.sv]
// testbench for the ordered completion ring tracker: random claims and completions checked against a slot tracker
module tb_top;
  import ocrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    opcode_t     op;
    logic        from_uplink;
    logic        is_linear;
    logic [15:0] frame_len;
    logic [31:0] consumer_index;
    logic [6:0]  done_slot;
    logic        cons_from_claim;
    logic        slot_from_open;
  } ring_req_t;

  typedef struct {
    logic        accepted;
    logic [6:0]  slot;
    drop_t       drop_reason;
    logic [31:0] published_producer;
  } ring_rsp_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ocrt_req_if req_ch ();
  ocrt_rsp_if rsp_ch ();

  ordered_completion_ring_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // tracker state
  logic [31:0] claim_ctr;
  logic [31:0] pub_ctr;
  logic        done_flag [RING_SLOTS];
  logic [15:0] len_limit;

  ring_req_t   request_q [$];
  ring_rsp_t   result_q [$];
  ring_req_t   cur_req;
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned gap_left;
  int unsigned stall_left;
  logic        idle_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic ring_rsp_t advance_ring(ring_req_t r);
    ring_rsp_t   o;
    logic [31:0] p;
    int unsigned n;
    o.accepted    = 1'b0;
    o.slot        = '0;
    o.drop_reason = DROP_NONE;
    if (r.op == OP_COMPLETE) begin
      if (r.done_slot < RING_SLOTS) done_flag[r.done_slot] = 1'b1;
      p = pub_ctr;
      n = 0;
      while (n < RING_SLOTS && p != claim_ctr && done_flag[p % RING_SLOTS]) begin
        done_flag[p % RING_SLOTS] = 1'b0;
        p = p + 32'd1;
        n++;
      end
      pub_ctr    = p;
      o.accepted = 1'b1;
      o.slot     = r.done_slot;
    end else if (!r.from_uplink) begin
      o.drop_reason = DROP_NOT_UPLINK;
    end else if (!r.is_linear) begin
      o.drop_reason = DROP_NONLINEAR;
    end else if (r.frame_len == 16'd0 || r.frame_len > len_limit) begin
      o.drop_reason = DROP_BAD_LEN;
    end else if (32'(claim_ctr - r.consumer_index) >= 32'(RING_SLOTS)) begin
      o.drop_reason = DROP_RING_FULL;
    end else begin
      o.slot     = 7'(claim_ctr % RING_SLOTS);
      claim_ctr  = claim_ctr + 32'd1;
      o.accepted = 1'b1;
    end
    o.published_producer = pub_ctr;
    return o;
  endfunction

  function automatic ring_req_t claim_req(logic up, logic lin, logic [15:0] len,
                                          logic [31:0] cons, logic rel);
    ring_req_t r;
    r.op              = OP_CLAIM;
    r.from_uplink     = up;
    r.is_linear       = lin;
    r.frame_len       = len;
    r.consumer_index  = cons;
    r.done_slot       = 7'($urandom);
    r.cons_from_claim = rel;
    r.slot_from_open  = 1'b0;
    return r;
  endfunction

  function automatic ring_req_t complete_req(logic [6:0] s, logic pick);
    ring_req_t r;
    r.op              = OP_COMPLETE;
    r.from_uplink     = 1'($urandom);
    r.is_linear       = 1'($urandom);
    r.frame_len       = 16'($urandom);
    r.consumer_index  = $urandom;
    r.done_slot       = s;
    r.cons_from_claim = 1'b0;
    r.slot_from_open  = pick;
    return r;
  endfunction

  function automatic ring_req_t random_req();
    int unsigned k;
    logic [15:0] len;
    logic [31:0] ofs;
    k = $urandom_range(0, 99);
    if (k < 46) begin
      case ($urandom_range(0, 5))
        0:       len = len_limit;
        1:       len = 16'd1;
        2:       len = len_limit + 16'd1;
        default: len = (len_limit > 0) ? 16'($urandom_range(1, len_limit)) : 16'd1;
      endcase
      ofs = ($urandom_range(0, 9) == 0) ? $urandom_range(RING_SLOTS, RING_SLOTS + 12)
                                        : $urandom_range(0, RING_SLOTS - 1);
      return claim_req(1'b1, 1'b1, len, ofs, 1'b1);
    end else if (k < 88) begin
      return complete_req(7'($urandom), 1'b1);
    end
    if ($urandom_range(0, 1)) return complete_req(7'($urandom), 1'b0);
    return claim_req(1'($urandom), 1'($urandom), 16'($urandom), $urandom, 1'b0);
  endfunction

  task automatic queue_req(ring_req_t r);
    request_q.push_back(r);
    n_queued++;
  endtask

  task automatic write_limit(logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_limit = v;
  endtask

  task automatic drain();
    while (!(n_taken == n_queued && result_q.size() == 0)) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    logic        nv;
    int unsigned span;
    nv = req_ch.valid;
    if (rst) begin
      nv       = 1'b0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        result_q.push_back(advance_ring(cur_req));
        n_taken++;
        nv       = 1'b0;
        gap_left = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          if (cur_req.cons_from_claim) begin
            cur_req.consumer_index = claim_ctr - cur_req.consumer_index;
          end
          span = claim_ctr - pub_ctr;
          if (cur_req.slot_from_open && span > 0) begin
            cur_req.done_slot = 7'((pub_ctr + $urandom_range(0, span - 1)) % RING_SLOTS);
          end
          req_ch.opcode         <= cur_req.op;
          req_ch.from_uplink    <= cur_req.from_uplink;
          req_ch.is_linear      <= cur_req.is_linear;
          req_ch.frame_len      <= cur_req.frame_len;
          req_ch.consumer_index <= cur_req.consumer_index;
          req_ch.done_slot      <= cur_req.done_slot;
          nv = 1'b1;
        end
      end
    end
    req_ch.valid <= nv;
  end

  // result monitor
  always @(posedge clk) begin
    ring_rsp_t w;
    logic      nr;
    if (rst) begin
      nr         = 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          w = result_q.pop_front();
          if (rsp_ch.accepted !== w.accepted) begin
            $error("accepted: expected %0d, got %0d", w.accepted, rsp_ch.accepted);
            errors++;
          end
          if (rsp_ch.slot !== w.slot) begin
            $error("slot: expected %0d, got %0d", w.slot, rsp_ch.slot);
            errors++;
          end
          if (rsp_ch.drop_reason !== w.drop_reason) begin
            $error("drop_reason: expected %0d, got %0d", w.drop_reason, rsp_ch.drop_reason);
            errors++;
          end
          if (rsp_ch.published_producer !== w.published_producer) begin
            $error("published_producer: expected %0h, got %0h", w.published_producer,
                   rsp_ch.published_producer);
            errors++;
          end
        end
        stall_left = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    rsp_ch.ready <= nr;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [15:0] limits [5];
    int unsigned counts [5];
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_CLAIM;
    req_ch.from_uplink    = 1'b0;
    req_ch.is_linear      = 1'b0;
    req_ch.frame_len      = '0;
    req_ch.consumer_index = '0;
    req_ch.done_slot      = '0;
    rsp_ch.ready          = 1'b0;
    claim_ctr             = '0;
    pub_ctr               = '0;
    len_limit             = MAX_FRAME_LEN_RESET;
    foreach (done_flag[i]) done_flag[i] = 1'b0;
    n_queued              = 0;
    n_taken               = 0;
    errors                = 0;
    cycle_cnt             = 0;
    idle_on               = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // drop priority, length bounds, ring full edge, out-of-order and stray completions
    queue_req(claim_req(1'b0, 1'b0, 16'd0, 32'd0, 1'b0));
    queue_req(claim_req(1'b1, 1'b0, 16'd0, 32'd0, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd0, 32'd0, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd9217, 32'd0, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'hFFFF, 32'd0, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd9216, 32'd0, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd1, 32'hFFFF_FFFF, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd64, 32'h8000_0000, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd64, 32'hFFFF_FF82, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd64, 32'hFFFF_FF83, 1'b0));
    queue_req(complete_req(7'd1, 1'b0));
    queue_req(complete_req(7'd2, 1'b0));
    queue_req(complete_req(7'd0, 1'b0));
    queue_req(complete_req(7'd127, 1'b0));
    queue_req(complete_req(7'd3, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd100, 32'd3, 1'b0));
    queue_req(complete_req(7'd5, 1'b0));
    queue_req(complete_req(7'd3, 1'b0));
    queue_req(claim_req(1'b1, 1'b1, 16'd1, 32'hFFFF_FFFF, 1'b0));
    repeat (150) queue_req(random_req());
    drain();

    limits = '{16'd1, 16'hFFFF, 16'd0, 16'd1500, 16'($urandom_range(1, 65535))};
    counts = '{200, 250, 100, 300, 250};
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      idle_on = (ph != 3);
      repeat (counts[ph]) queue_req(random_req());
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
